### design/quoted_string_unescape_utf8_top_defines.svh
`ifndef QUOTED_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH
`define QUOTED_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define QSU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define QSU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/qsu_pkg.sv
`timescale 1ns / 1ps

package qsu_pkg;

    localparam int unsigned CHAR_W = 21;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    localparam logic [CHAR_W-1:0] CH_QUOTE  = CHAR_W'('h22);
    localparam logic [CHAR_W-1:0] CH_BSLASH = CHAR_W'('h5C);
    localparam logic [CHAR_W-1:0] CH_N      = CHAR_W'('h6E);
    localparam logic [CHAR_W-1:0] CH_T      = CHAR_W'('h74);
    localparam logic [CHAR_W-1:0] CH_U      = CHAR_W'('h75);
    localparam logic [CHAR_W-1:0] CH_NL     = CHAR_W'('h0A);
    localparam logic [CHAR_W-1:0] CH_TAB    = CHAR_W'('h09);
    localparam logic [7:0]        BYTE_BSLASH = 8'h5C;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_STR  = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } scan_mode_t;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_CLOSE  = 2'd1,
        KIND_SYNTAX = 2'd2,
        KIND_UNTERM = 2'd3
    } kind_t;

    // One decoded character's worth of work for the back end:
    // optional backslash byte, optional code point, optional status word.
    typedef struct packed {
        logic              bs;
        logic              has_cp;
        logic [CHAR_W-1:0] cp;
        logic              has_tail;
        kind_t             tail_kind;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### design/quoted_string_unescape_utf8_top.sv
`timescale 1ns / 1ps
// Channel | Handshake            | Payload                      | Word
// input   | in_valid / in_ready  | in_char[20:0], end_of_text   | one source character
// output  | out_valid / out_ready| out_byte[7:0], kind, run_last| one decoded byte or status
//
// A character is taken every cycle while the four-entry command queue has room.
// Results leave at one word per cycle from the back end's output register while the
// output does not stall, so a character that decodes to n words holds the back end until
// all n have left; plain ASCII then runs at one character per cycle. out_valid for the
// first result rises after the queue and then the output register have been written.
// Reset (rst_n low, asynchronous) returns the scanner to idle and empties the queue.
// A stalled output fills the queue, after which in_ready drops.
`include "quoted_string_unescape_utf8_top_defines.svh"

module quoted_string_unescape_utf8_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [20:0] in_char,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [1:0]  kind,
    output logic        run_last
);
    import qsu_pkg::*;

    // front end -> queue
    logic      push;
    cmd_t      wr_cmd;
    // queue -> back end
    cmd_t      head;
    logic      pop;
    q_status_t q_stat;

    // Scanner: quote/escape/hex state, one character per cycle while the queue has room,
    // emits a command only when the character produces output.
    qsu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_char     (in_char),
        .end_of_text (end_of_text),
        .q_stat      (q_stat),
        .push        (push),
        .cmd         (wr_cmd)
    );

    // Decouples the scanner from output stalls and multi-byte expansion.
    qsu_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .head   (head),
        .q_stat (q_stat)
    );

    // Expander: walks backslash, UTF-8 bytes and status word of the head
    // command into the registered output.
    qsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .kind      (kind),
        .run_last  (run_last)
    );

    `QSU_ASSERT_IMP(a_no_push_full, push, !q_stat.full, "command pushed into full queue")
    `QSU_ASSERT_IMP(a_no_pop_empty, pop, !q_stat.empty, "command popped from empty queue")
    `QSU_ASSERT_IMP(a_status_last, out_valid && (kind != KIND_DATA), run_last && (out_byte == 8'h00), "status word not last or has nonzero byte")
    `QSU_ASSERT_NXT(a_push_fills, push && !pop && q_stat.empty, !q_stat.empty, "queue stayed empty after push")

endmodule

### design/qsu_front.sv
`timescale 1ns / 1ps

module qsu_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [20:0]           in_char,
    input  logic                  end_of_text,
    input  qsu_pkg::q_status_t    q_stat,
    output logic                  push,
    output qsu_pkg::cmd_t         cmd
);
    import qsu_pkg::*;

    scan_mode_t  mode_reg, mode_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] hex_acc_reg, hex_acc_next;
    logic        fire;
    logic        hex_ok;
    logic [3:0]  hex_val;

    assign in_ready = !q_stat.full;
    assign fire     = in_valid && in_ready;

    // lowercase hex digit decode
    always_comb
    begin
        hex_ok  = 1'b0;
        hex_val = in_char[3:0];
        if (in_char >= CHAR_W'('h30) && in_char <= CHAR_W'('h39))
        begin
            hex_ok = 1'b1;
        end
        else if (in_char >= CHAR_W'('h61) && in_char <= CHAR_W'('h66))
        begin
            hex_ok  = 1'b1;
            hex_val = in_char[3:0] + 4'd9;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            hex_cnt_reg <= 2'd0;
            hex_acc_reg <= 16'd0;
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            hex_acc_reg <= hex_acc_next;
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        hex_cnt_next  = hex_cnt_reg;
        hex_acc_next  = hex_acc_reg;
        cmd           = '0;
        cmd.cp        = in_char;
        cmd.tail_kind = KIND_DATA;

        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (in_char == CH_QUOTE)
                begin
                    mode_next = MODE_STR;
                end
                else
                begin
                    cmd.has_tail  = 1'b1;
                    cmd.tail_kind = KIND_SYNTAX;
                end
            end
            MODE_STR:
            begin
                priority if (in_char == CH_BSLASH)
                begin
                    mode_next = MODE_ESC;
                end
                else if (in_char == CH_QUOTE)
                begin
                    cmd.has_tail  = 1'b1;
                    cmd.tail_kind = KIND_CLOSE;
                    mode_next     = MODE_IDLE;
                end
                else
                begin
                    cmd.has_cp = 1'b1;
                end
            end
            MODE_ESC:
            begin
                mode_next = MODE_STR;
                priority if (in_char == CH_N || in_char == CH_NL)
                begin
                    cmd.has_cp = 1'b1;
                    cmd.cp     = CH_NL;
                end
                else if (in_char == CH_T)
                begin
                    cmd.has_cp = 1'b1;
                    cmd.cp     = CH_TAB;
                end
                else if (in_char == CH_BSLASH)
                begin
                    cmd.has_cp = 1'b1;
                    cmd.cp     = CH_BSLASH;
                end
                else if (in_char == CH_U)
                begin
                    mode_next    = MODE_HEX;
                    hex_cnt_next = 2'd0;
                    hex_acc_next = 16'd0;
                end
                else
                begin
                    // unknown escape passes through with its backslash
                    cmd.bs     = 1'b1;
                    cmd.has_cp = 1'b1;
                end
            end
            MODE_HEX:
            begin
                if (!hex_ok)
                begin
                    cmd.has_tail  = 1'b1;
                    cmd.tail_kind = KIND_SYNTAX;
                    mode_next     = MODE_IDLE;
                    hex_cnt_next  = 2'd0;
                    hex_acc_next  = 16'd0;
                end
                else if (hex_cnt_reg == 2'd3)
                begin
                    cmd.has_cp   = 1'b1;
                    cmd.cp       = {5'd0, hex_acc_reg[11:0], hex_val};
                    mode_next    = MODE_STR;
                    hex_cnt_next = 2'd0;
                    hex_acc_next = 16'd0;
                end
                else
                begin
                    hex_acc_next = {hex_acc_reg[11:0], hex_val};
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        if (end_of_text && mode_next != MODE_IDLE)
        begin
            cmd.has_tail  = 1'b1;
            cmd.tail_kind = KIND_UNTERM;
            mode_next     = MODE_IDLE;
            hex_cnt_next  = 2'd0;
            hex_acc_next  = 16'd0;
        end
    end

    assign push = fire && (cmd.bs || cmd.has_cp || cmd.has_tail);

endmodule

### design/qsu_queue.sv
`timescale 1ns / 1ps

module qsu_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  qsu_pkg::cmd_t      wr_cmd,
    input  logic               pop,
    output qsu_pkg::cmd_t      head,
    output qsu_pkg::q_status_t q_stat
);
    import qsu_pkg::*;

    cmd_t           q_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg, count_next;

    assign head         = q_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == (QAW+1)'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

### design/qsu_back.sv
`timescale 1ns / 1ps

module qsu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  qsu_pkg::cmd_t      head,
    input  qsu_pkg::q_status_t q_stat,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic [1:0]         kind,
    output logic               run_last
);
    import qsu_pkg::*;

    logic [2:0] pos_reg, pos_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    kind_t      kind_reg;
    logic       run_last_reg;

    logic [1:0] cls;
    logic [2:0] len;
    logic [2:0] total;
    logic [2:0] j;
    logic       fire;
    logic       is_last;
    logic [7:0] cur_byte;
    kind_t      cur_kind;

    // byte jj of the UTF-8 form, class c = byte count - 1
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] c,
                                             input logic [1:0] jj);
        logic [7:0] b;
        b = 8'h00;
        unique case (c)
            2'd0: b = {1'b0, cp[6:0]};
            2'd1:
            begin
                if (jj == 2'd0) b = {3'b110, cp[10:6]};
                else            b = {2'b10, cp[5:0]};
            end
            2'd2:
            begin
                unique case (jj)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default:
            begin
                unique case (jj)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

    always_comb
    begin
        priority if (head.cp[20:16] != '0) cls = 2'd3;
        else if (head.cp[15:11] != '0)     cls = 2'd2;
        else if (head.cp[10:7] != '0)      cls = 2'd1;
        else                               cls = 2'd0;
    end

    assign len   = {1'b0, cls} + 3'd1;
    assign total = {2'b0, head.bs} + (head.has_cp ? len : 3'd0) + {2'b0, head.has_tail};
    assign j     = pos_reg - {2'b0, head.bs};

    always_comb
    begin
        cur_byte = 8'h00;
        cur_kind = KIND_DATA;
        priority if (head.bs && pos_reg == 3'd0)
        begin
            cur_byte = BYTE_BSLASH;
        end
        else if (head.has_cp && j < len)
        begin
            cur_byte = utf8_byte(head.cp, cls, j[1:0]);
        end
        else
        begin
            cur_kind = head.tail_kind;
        end
    end

    assign is_last = (pos_reg == total - 3'd1);
    assign fire    = !q_stat.empty && (!out_valid_reg || out_ready);
    assign pop     = fire && is_last;

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
            pos_next       = is_last ? 3'd0 : pos_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg <= cur_byte;
            kind_reg     <= cur_kind;
            run_last_reg <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign kind      = kind_reg;
    assign run_last  = run_last_reg;

endmodule
